>>> rtl/u8san_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8san_pkg
// Shared types and constants of the UTF-8 sanitiser: the run descriptor
// handed from the classifier to the expander, and the code point limits.
// ----------------------------------------------------------------------------
package u8san_pkg;

   // number of tokens one request can produce at most
   localparam int unsigned MaxTokens = 4;

   // default depth of the queue between classifier and expander
   localparam int unsigned DefaultQueueDepth = 2;

   // replacement character U+FFFD as UTF-8
   localparam logic [7:0] Fffd0 = 8'hEF;
   localparam logic [7:0] Fffd1 = 8'hBF;
   localparam logic [7:0] Fffd2 = 8'hBD;

   // code point limits of the range check
   localparam logic [10:0] CpMin2     = 11'h080;
   localparam logic [15:0] CpMin3     = 16'h0800;
   localparam logic [15:0] SurrLow    = 16'hD800;
   localparam logic [15:0] SurrHigh   = 16'hDFFF;
   localparam logic [20:0] CpMin4     = 21'h010000;
   localparam logic [20:0] CpMax      = 21'h10FFFF;

   // one run of result tokens; a token is a literal byte or one U+FFFD
   typedef struct packed {
      logic [2:0]                     cnt;
      logic [MaxTokens-1:0]           fffd;
      logic [MaxTokens-1:0][7:0]      data;
      logic                           done;
   } cmd_type;

endpackage

>>> rtl/utf8_sanitizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_sanitizer
// Streaming UTF-8 validator that replaces bad sequences with U+FFFD.
// ----------------------------------------------------------------------------
// Usage
//  - request channel req_*: one raw byte per request, req_end_of_text on the
//    final byte of a string. Taken when req_valid is high and req_stall low.
//  - result channel rsp_*: one byte per result; rsp_last_of_run closes the
//    bytes caused by one request, rsp_text_done closes a string.
//  - a request may cause no result (an incomplete sequence is held) or up to
//    twelve bytes (four replacement characters).
//  - the first result of a request passes through the queue and then the
//    result register. One request a cycle is taken while every request gives
//    at most one byte and rsp_stall is low; the expander emits one byte per
//    cycle while rsp_stall is low.
//  - a short queue of run descriptors sits between classifier and expander;
//    req_stall rises only when that queue is full.
//  - when rsp_stall is high the result register holds its byte and the queue
//    fills behind it.
//  - reset closes any open sequence and empties the queue and the result
//    register; the block takes requests from the first cycle after reset.
// ----------------------------------------------------------------------------
module utf8_sanitizer #(
   parameter int unsigned QUEUE_DEPTH = u8san_pkg::DefaultQueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   output logic       rsp_text_done
);
   import u8san_pkg::*;

   logic    accept;
   logic    push;
   logic    pop;
   logic    full;
   logic    head_valid;
   cmd_type push_cmd;
   cmd_type head_cmd;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   u8san_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .end_of_text (req_end_of_text),
      .push        (push),
      .cmd         (push_cmd)
   );

   u8san_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   u8san_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_cmd        (head_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_text_done   (rsp_text_done)
   );

endmodule

>>> rtl/u8san_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8san_front
// Classifier: holds the open multi-byte sequence, checks it when complete
// and turns each request that gives tokens into a run descriptor for the expander.
// ----------------------------------------------------------------------------
module u8san_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         in_byte,
   input  logic               end_of_text,
   output logic               push,
   output u8san_pkg::cmd_type cmd
);
   import u8san_pkg::*;

   logic [2:0][7:0] held_ff;
   logic [2:0][7:0] held_in;
   logic [1:0]      held_cnt_ff;
   logic [1:0]      held_cnt_in;
   logic [2:0]      seq_len_ff;
   logic [2:0]      seq_len_in;

   logic        is_open;
   logic        is_cont;
   logic        is_ascii;
   logic [2:0]  lead_len;
   logic        seq_ok;
   logic        valid_case;
   logic [1:0]  prefix;
   logic [2:0]  tok_cnt;
   logic [3:0]  lit_mask;
   logic [10:0] cp2;
   logic [15:0] cp3;
   logic [20:0] cp4;

   assign is_cont  = (in_byte[7:6] == 2'b10);
   assign is_ascii = !in_byte[7];
   assign is_open  = (seq_len_ff != 3'd0) && (held_cnt_ff != 2'd0)
                     && ({1'b0, held_cnt_ff} < seq_len_ff);

   always_comb begin
      if (in_byte[7:5] == 3'b110) begin
         lead_len = 3'd2;
      end else if (in_byte[7:4] == 4'b1110) begin
         lead_len = 3'd3;
      end else if (in_byte[7:3] == 5'b11110) begin
         lead_len = 3'd4;
      end else begin
         lead_len = 3'd0;
      end
   end

   // code point of the sequence that this byte would complete
   assign cp2 = {held_ff[0][4:0], in_byte[5:0]};
   assign cp3 = {held_ff[0][3:0], held_ff[1][5:0], in_byte[5:0]};
   assign cp4 = {held_ff[0][2:0], held_ff[1][5:0], held_ff[2][5:0], in_byte[5:0]};

   always_comb begin
      case (seq_len_ff)
         3'd2: begin
            seq_ok = (cp2 >= CpMin2);
         end
         3'd3: begin
            seq_ok = (cp3 >= CpMin3) && ((cp3 < SurrLow) || (cp3 > SurrHigh));
         end
         default: begin
            seq_ok = (cp4 >= CpMin4) && (cp4 <= CpMax);
         end
      endcase
   end

   always_comb begin
      held_in     = held_ff;
      held_cnt_in = held_cnt_ff;
      seq_len_in  = seq_len_ff;
      tok_cnt     = 3'd0;
      lit_mask    = 4'h0;
      valid_case  = 1'b0;
      prefix      = 2'd0;
      if (is_open && is_cont) begin
         if (({1'b0, held_cnt_ff} + 3'd1) == seq_len_ff) begin
            held_cnt_in = 2'd0;
            seq_len_in  = 3'd0;
            tok_cnt     = {1'b0, held_cnt_ff} + 3'd1;
            if (seq_ok) begin
               valid_case = 1'b1;
               lit_mask   = 4'hF;
            end
         end else begin
            if (held_cnt_ff != 2'd3) begin
               held_in[held_cnt_ff] = in_byte;
               held_cnt_in          = held_cnt_ff + 2'd1;
            end
            // string ends inside the sequence: every byte taken so far fails
            if (end_of_text) begin
               tok_cnt     = {1'b0, held_cnt_ff} + 3'd1;
               held_cnt_in = 2'd0;
               seq_len_in  = 3'd0;
            end
         end
      end else begin
         prefix      = is_open ? held_cnt_ff : 2'd0;
         held_cnt_in = 2'd0;
         seq_len_in  = 3'd0;
         if (is_ascii) begin
            tok_cnt          = {1'b0, prefix} + 3'd1;
            lit_mask[prefix] = 1'b1;
         end else if (lead_len != 3'd0) begin
            if (end_of_text) begin
               tok_cnt = {1'b0, prefix} + 3'd1;
            end else begin
               tok_cnt     = {1'b0, prefix};
               held_in[0]  = in_byte;
               held_cnt_in = 2'd1;
               seq_len_in  = lead_len;
            end
         end else begin
            tok_cnt = {1'b0, prefix} + 3'd1;
         end
      end
   end

   always_comb begin
      cmd.cnt     = tok_cnt;
      cmd.fffd    = ~lit_mask;
      cmd.done    = end_of_text;
      cmd.data[0] = (valid_case && (held_cnt_ff > 2'd0)) ? held_ff[0] : in_byte;
      cmd.data[1] = (valid_case && (held_cnt_ff > 2'd1)) ? held_ff[1] : in_byte;
      cmd.data[2] = (valid_case && (held_cnt_ff > 2'd2)) ? held_ff[2] : in_byte;
      cmd.data[3] = in_byte;
   end

   assign push = accept && (tok_cnt != 3'd0);

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_cnt_ff <= 2'd0;
         seq_len_ff  <= 3'd0;
      end else if (accept) begin
         held_cnt_ff <= held_cnt_in;
         seq_len_ff  <= seq_len_in;
      end
   end

   // an open sequence always still misses a byte, and no bytes without one
   a_seq_shape: assert property (@(posedge clock) disable iff (reset)
      (seq_len_ff == 3'd0) ? (held_cnt_ff == 2'd0)
                           : (({1'b0, held_cnt_ff} < seq_len_ff) && (held_cnt_ff != 2'd0)))
      else $error("held count out of step with sequence length");

endmodule

>>> rtl/u8san_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8san_queue
// Short queue of run descriptors between classifier and expander.
// ----------------------------------------------------------------------------
module u8san_queue #(
   parameter int unsigned DEPTH = u8san_pkg::DefaultQueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u8san_pkg::cmd_type push_cmd,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output u8san_pkg::cmd_type head_cmd
);
   import u8san_pkg::*;

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   cmd_type           slot_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff;
   logic [PtrW-1:0]   wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff;
   logic [PtrW-1:0]   rd_ptr_in;
   logic [CntW-1:0]   count_ff;
   logic [CntW-1:0]   count_in;

   assign full       = (count_ff == FullCnt);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from an empty queue");

endmodule

>>> rtl/u8san_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8san_back
// Expander: walks the tokens of the head run, spells each replacement as
// three bytes and drives the registered result channel.
// ----------------------------------------------------------------------------
module u8san_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  u8san_pkg::cmd_type head_cmd,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last_of_run,
   output logic               rsp_text_done
);
   import u8san_pkg::*;

   logic [1:0] tok_idx_ff;
   logic [1:0] tok_idx_in;
   logic [1:0] sub_ff;
   logic [1:0] sub_in;
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       done_ff;

   logic       load;
   logic       cur_fffd;
   logic [7:0] cur_byte;
   logic       tok_end;
   logic       run_end;

   assign load     = head_valid && (!valid_ff || !rsp_stall);
   assign cur_fffd = head_cmd.fffd[tok_idx_ff];

   always_comb begin
      if (cur_fffd) begin
         case (sub_ff)
            2'd0:    cur_byte = Fffd0;
            2'd1:    cur_byte = Fffd1;
            default: cur_byte = Fffd2;
         endcase
      end else begin
         cur_byte = head_cmd.data[tok_idx_ff];
      end
   end

   assign tok_end = !cur_fffd || (sub_ff == 2'd2);
   assign run_end = tok_end && ({1'b0, tok_idx_ff} == (head_cmd.cnt - 3'd1));
   assign pop     = load && run_end;

   always_comb begin
      tok_idx_in = tok_idx_ff;
      sub_in     = sub_ff;
      if (load) begin
         if (run_end) begin
            tok_idx_in = 2'd0;
            sub_in     = 2'd0;
         end else if (tok_end) begin
            tok_idx_in = tok_idx_ff + 2'd1;
            sub_in     = 2'd0;
         end else begin
            sub_in = sub_ff + 2'd1;
         end
      end
      valid_in = load || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_idx_ff <= 2'd0;
         sub_ff     <= 2'd0;
         valid_ff   <= 1'b0;
      end else begin
         tok_idx_ff <= tok_idx_in;
         sub_ff     <= sub_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= cur_byte;
         last_ff <= run_end;
         done_ff <= run_end && head_cmd.done;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_text_done   = done_ff;

   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> ((head_cmd.cnt != 3'd0) && (head_cmd.cnt <= 3'd4)))
      else $error("run with no or too many tokens");

   a_literal_whole: assert property (@(posedge clock) disable iff (reset)
      (head_valid && !cur_fffd) |-> (sub_ff == 2'd0))
      else $error("literal token entered mid replacement");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && done_ff) |-> last_ff)
      else $error("end of text on a byte that does not close its run");

endmodule
